// ===== rtl/core/krt_pkg.sv =====
`default_nettype none

package krt_pkg;

    localparam int TOTAL_W = 7;

    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_LIST   = 3'd1,
        CMD_SEARCH = 3'd2,
        CMD_UPDATE = 3'd3,
        CMD_DELETE = 3'd4
    } cmd_e;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_MISS  = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } status_e;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_LIST_RD,
        S_LIST_OUT,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_EMIT
    } state_e;

    typedef enum logic [1:0] {
        WR_ADD,
        WR_UPDATE,
        WR_SHIFT
    } wr_src_e;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] key;
        logic [31:0]        price_bits;
        logic signed [31:0] quantity;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] record_key;
        logic [31:0]        record_price;
        logic signed [31:0] record_quantity;
        logic [TOTAL_W-1:0] entry_total;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] key;
        logic [31:0]        price;
        logic signed [31:0] quantity;
    } rec_t;

    typedef struct packed {
        logic    accept;
        logic    idx_inc;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    wr_en;
        wr_src_e wr_src;
        logic    rd_next;
        logic    res_rec;
        logic    res_code;
        status_e code;
        logic    out_res;
        logic    out_list;
    } ctrl_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic idx_end;
        logic hit;
        logic shift_end;
        logic list_last;
        logic out_free;
        logic is_update;
        logic is_delete;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/krt_ram.sv =====
`default_nettype none

module krt_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  wire logic                                    clk,
    input  wire logic                                    wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                        wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/krt_ctrl.sv =====
`default_nettype none

module krt_ctrl import krt_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    input  wire logic [2:0] req_command,
    output logic            req_stall,
    input  wire dp_stat_t   stat,
    output ctrl_cmd_t       cmd
);

    state_e state_reg;
    state_e state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req_command) inside
                        CMD_ADD:                                state_next = S_ADD;
                        CMD_LIST:                               state_next = S_LIST_RD;
                        CMD_SEARCH, CMD_UPDATE, CMD_DELETE:     state_next = S_SRCH_RD;
                        default:                                state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD:      state_next = S_EMIT;
            S_LIST_RD:  state_next = stat.empty ? S_EMIT : S_LIST_OUT;
            S_LIST_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.list_last ? S_IDLE : S_LIST_RD;
                end
            end
            S_SRCH_RD:  state_next = stat.idx_end ? S_EMIT : S_SRCH_CHK;
            S_SRCH_CHK:
            begin
                if (stat.hit)
                begin
                    state_next = stat.is_delete ? S_SHIFT_RD : S_EMIT;
                end
                else
                begin
                    state_next = S_SRCH_RD;
                end
            end
            S_SHIFT_RD: state_next = stat.shift_end ? S_EMIT : S_SHIFT_WR;
            S_SHIFT_WR: state_next = S_SHIFT_RD;
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd = '{
            accept:   1'b0,
            idx_inc:  1'b0,
            cnt_inc:  1'b0,
            cnt_dec:  1'b0,
            wr_en:    1'b0,
            wr_src:   WR_ADD,
            rd_next:  1'b0,
            res_rec:  1'b0,
            res_code: 1'b0,
            code:     STAT_OK,
            out_res:  1'b0,
            out_list: 1'b0
        };
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = req_valid;
            end
            S_ADD:
            begin
                cmd.res_code = 1'b1;
                if (stat.full)
                begin
                    cmd.code = STAT_FULL;
                end
                else
                begin
                    cmd.code    = STAT_OK;
                    cmd.wr_en   = 1'b1;
                    cmd.wr_src  = WR_ADD;
                    cmd.cnt_inc = 1'b1;
                end
            end
            S_LIST_RD:
            begin
                if (stat.empty)
                begin
                    cmd.res_code = 1'b1;
                    cmd.code     = STAT_EMPTY;
                end
            end
            S_LIST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_list = 1'b1;
                    cmd.idx_inc  = 1'b1;
                end
            end
            S_SRCH_RD:
            begin
                if (stat.idx_end)
                begin
                    cmd.res_code = 1'b1;
                    cmd.code     = STAT_MISS;
                end
            end
            S_SRCH_CHK:
            begin
                if (stat.hit)
                begin
                    cmd.res_rec = 1'b1;
                    if (stat.is_update)
                    begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_src = WR_UPDATE;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_SHIFT_RD:
            begin
                cmd.rd_next = 1'b1;
                if (stat.shift_end)
                begin
                    cmd.cnt_dec = 1'b1;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_src  = WR_SHIFT;
                cmd.idx_inc = 1'b1;
            end
            S_EMIT:
            begin
                cmd.out_res = stat.out_free;
            end
            default:
            begin
                cmd.accept = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/krt_dp.sv =====
`default_nettype none

module krt_dp import krt_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire ctrl_cmd_t cmd,
    output dp_stat_t       stat,
    input  wire in_item_t  req,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output out_item_t      rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [2:0]         cmd_reg;
    logic signed [31:0] key_reg;
    logic [31:0]        price_reg;
    logic signed [31:0] qty_reg;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      cnt_next;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      idx_next;
    logic [CW-1:0]      idx_plus;
    rec_t               res_reg;
    status_e            res_status_reg;
    out_item_t          out_reg;
    out_item_t          out_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    rec_t               wr_data;
    logic [AW-1:0]      rd_addr;
    rec_t               rd_data;
    rec_t               hit_rec;

    krt_ram #(
        .WIDTH ($bits(rec_t)),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign idx_plus = idx_reg + CW'(1);
    assign rd_addr  = cmd.rd_next ? idx_plus[AW-1:0] : idx_reg[AW-1:0];

    // record as returned on a hit, quantity replaced on update
    always_comb
    begin
        hit_rec = rd_data;
        if (cmd_reg == CMD_UPDATE)
        begin
            hit_rec.quantity = qty_reg;
        end
    end

    always_comb
    begin
        wr_en   = cmd.wr_en;
        wr_addr = idx_reg[AW-1:0];
        wr_data = rd_data;
        case (cmd.wr_src)
            WR_ADD:
            begin
                wr_addr = cnt_reg[AW-1:0];
                wr_data = '{key: key_reg, price: price_reg, quantity: qty_reg};
            end
            WR_UPDATE: wr_data = hit_rec;
            WR_SHIFT:  wr_data = rd_data;
            default:   wr_data = rd_data;
        endcase
    end

    always_comb
    begin
        stat.full      = (cnt_reg == CW'(CAPACITY));
        stat.empty     = (cnt_reg == '0);
        stat.idx_end   = (idx_reg == cnt_reg);
        stat.hit       = (rd_data.key == key_reg);
        stat.shift_end = (idx_plus >= cnt_reg);
        stat.list_last = (idx_plus == cnt_reg);
        stat.out_free  = !out_valid_reg || !rsp_stall;
        stat.is_update = (cmd_reg == CMD_UPDATE);
        stat.is_delete = (cmd_reg == CMD_DELETE);
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            cnt_next = cnt_reg - CW'(1);
        end

        idx_next = idx_reg;
        if (cmd.accept)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_plus;
        end
    end

    // output register
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        if (cmd.out_list)
        begin
            out_next = '{
                status:          STAT_OK,
                record_key:      rd_data.key,
                record_price:    rd_data.price,
                record_quantity: rd_data.quantity,
                entry_total:     TOTAL_W'(cnt_reg),
                last:            stat.list_last
            };
            out_valid_next = 1'b1;
        end
        else if (cmd.out_res)
        begin
            out_next = '{
                status:          res_status_reg,
                record_key:      res_reg.key,
                record_price:    res_reg.price,
                record_quantity: res_reg.quantity,
                entry_total:     TOTAL_W'(cnt_reg),
                last:            1'b1
            };
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmd_reg   <= req.command;
            key_reg   <= req.key;
            price_reg <= req.price_bits;
            qty_reg   <= req.quantity;
        end
        if (cmd.res_rec)
        begin
            res_reg        <= hit_rec;
            res_status_reg <= STAT_OK;
        end
        else if (cmd.res_code)
        begin
            res_reg        <= '0;
            res_status_reg <= cmd.code;
        end
        out_reg <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

`default_nettype wire

// ===== rtl/core/keyed_record_table_unit.sv =====
// keyed record table: up to CAPACITY records of key, price word and quantity
// request channel (req_valid / req_stall / req) carries one command per transfer;
// commands are add, list, search, update quantity and delete
// response channel (rsp_valid / rsp_stall / rsp) returns one transfer per result,
// list gives one per stored record in slot order with last on the final one
// one command is worked at a time; req_stall is high from the accepting edge
// until the final response is loaded into the output register
// records sit in a single-port-write, registered-read ram; each step through
// the table takes an address state, then a compare or move state
// add: the record is written at the slot given by the count, or full is answered
// search / update: slots are read and compared from slot 0 up to a hit or a miss
// delete moves each later record down one slot after the hit to close the gap
// list: each record is read, then loaded for output before the next is read
// a stalled response holds in the output register and the block waits
// reset clears the record count and the control state; ram contents are
// never cleared, since only slots below the count are read
// unknown command codes are taken and give no response
`default_nettype none

module keyed_record_table_unit import krt_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire in_item_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output out_item_t     rsp
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    krt_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_command (req.command),
        .req_stall   (req_stall),
        .stat        (stat),
        .cmd         (cmd)
    );

    krt_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
